>>> rtl/core/pixel_format_converter_defines.svh
// Assertion macros for the pixel format converter.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef PIXEL_FORMAT_CONVERTER_DEFINES_SVH
`define PIXEL_FORMAT_CONVERTER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PFC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define PFC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/pfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pfc_pkg;

	// Register indexes on the configuration channel
	localparam logic [1:0] REG_SOURCE_FORMAT = 2'd0;
	localparam logic [1:0] REG_DEST_FORMAT   = 2'd1;
	localparam logic [1:0] REG_INVERT_ENABLE = 2'd2;

	// Source format codes
	localparam logic [2:0] SRC_G1      = 3'd0;
	localparam logic [2:0] SRC_G2      = 3'd1;
	localparam logic [2:0] SRC_G4      = 3'd2;
	localparam logic [2:0] SRC_G8      = 3'd3;
	localparam logic [2:0] SRC_RGBX222 = 3'd4;
	localparam logic [2:0] SRC_RGB565  = 3'd5;
	localparam logic [2:0] SRC_RGB888  = 3'd6;

	// Destination format codes
	localparam logic [2:0] DST_G1     = 3'd0;
	localparam logic [2:0] DST_G2     = 3'd1;
	localparam logic [2:0] DST_G4     = 3'd2;
	localparam logic [2:0] DST_G8     = 3'd3;
	localparam logic [2:0] DST_RGB565 = 3'd4;
	localparam logic [2:0] DST_RGB888 = 3'd5;

	// BT.601 luma weights, sum 256
	localparam logic [15:0] LUMA_R = 16'd77;
	localparam logic [15:0] LUMA_G = 16'd150;
	localparam logic [15:0] LUMA_B = 16'd29;

	typedef struct packed {
		logic [2:0] source_format;
		logic [2:0] dest_format;
		logic       invert_enable;
	} cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/pixel_format_converter.sv
// Pixel format converter: takes one native source pixel per s_tdata beat and returns it
// in the destination framebuffer format on m_tdata, one result beat per input beat, in
// order. The source is masked to its depth, expanded to 8-bit RGB and quantised to the
// destination (BT.601 luma for gray targets, channel truncation for RGB565/RGB888);
// matching formats pass through, and invert_enable complements the result within the
// destination depth. The block sustains one pixel per clock while m_tready stays high:
// a beat sits in the input register while the expand and pack logic works on it, then
// lands in the output register, which drives m_tdata until m_tready takes it.
// The output register lets a new beat be taken while a finished one waits. Write the
// configuration registers only while no beat is in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "pixel_format_converter_defines.svh"

module pixel_format_converter
	import pfc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input pixels
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // [23:0] source_pixel
	// Converted pixels
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [23:0] m_tdata,   // [23:0] dest_pixel
	// Register writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [2:0]  cfg_data
);

	cfg_t        cfg;
	logic        vld_s1;
	logic [23:0] pix_s1;
	logic        vld_s2;
	logic [23:0] pix_s2;
	logic        adv_s2;
	logic [23:0] masked;
	logic [23:0] rgb;
	logic [23:0] conv;

	pfc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Output register can load when empty or when its beat is being taken
	assign adv_s2   = !vld_s2 || m_tready;
	// Input register can load when empty or when it hands on its beat
	assign s_tready = !vld_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	// Hold the pixel until it moves on
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			pix_s1 <= s_tdata;
		end
	end

	pfc_expand u_expand (
		.source_format (cfg.source_format),
		.pixel         (pix_s1),
		.masked        (masked),
		.rgb           (rgb)
	);

	pfc_pack u_pack (
		.cfg       (cfg),
		.masked    (masked),
		.rgb       (rgb),
		.pixel_out (conv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && vld_s1) begin
			pix_s2 <= conv;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = pix_s2;

	// A full pipe with a stalled output must refuse new beats
	`PFC_ASSERT_NOW(a_stall_blocks_input, vld_s1 && vld_s2 && !m_tready, !s_tready, "input taken while pipe is full and stalled")
	// A beat in the input register reaches the output once there is room
	`PFC_ASSERT_NEXT(a_s1_moves_on, vld_s1 && adv_s2, m_tvalid, "beat lost between input and output registers")
	// Gray 1-bit results never carry bits above the destination depth
	`PFC_ASSERT_NOW(a_g1_depth, cfg.dest_format == DST_G1, conv[23:1] == 23'd0, "result exceeds 1-bit destination depth")
	// Unknown destination formats yield a zero pixel
	`PFC_ASSERT_NOW(a_bad_dest_zero, cfg.dest_format > DST_RGB888, conv == 24'd0, "undefined destination gives non-zero pixel")

endmodule

`default_nettype wire

>>> rtl/core/pfc_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module pfc_cfg_regs
	import pfc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [2:0] cfg_data,
	output cfg_t            cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SOURCE_FORMAT: cfg_q.source_format <= cfg_data;
				REG_DEST_FORMAT:   cfg_q.dest_format   <= cfg_data;
				REG_INVERT_ENABLE: cfg_q.invert_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/pfc_expand.sv
`timescale 1ns / 1ps
`default_nettype none

module pfc_expand
	import pfc_pkg::*;
(
	input  wire logic [2:0]  source_format,
	input  wire logic [23:0] pixel,
	output logic      [23:0] masked,
	output logic      [23:0] rgb
);

	// Gray scaling to full range is bit replication (x255, x85, x17, x1)
	always_comb begin
		case (source_format)
			SRC_G1: begin
				masked = {23'd0, pixel[0]};
				rgb    = {24{pixel[0]}};
			end
			SRC_G2: begin
				masked = {22'd0, pixel[1:0]};
				rgb    = {12{pixel[1:0]}};
			end
			SRC_G4: begin
				masked = {20'd0, pixel[3:0]};
				rgb    = {6{pixel[3:0]}};
			end
			SRC_G8: begin
				masked = {16'd0, pixel[7:0]};
				rgb    = {3{pixel[7:0]}};
			end
			SRC_RGBX222: begin
				masked = {18'd0, pixel[5:0]};
				rgb    = {{4{pixel[5:4]}}, {4{pixel[3:2]}}, {4{pixel[1:0]}}};
			end
			SRC_RGB565: begin
				masked = {8'd0, pixel[15:0]};
				rgb    = {pixel[15:11], 3'd0, pixel[10:5], 2'd0, pixel[4:0], 3'd0};
			end
			SRC_RGB888: begin
				masked = pixel;
				rgb    = pixel;
			end
			default: begin
				masked = '0;
				rgb    = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/core/pfc_pack.sv
`timescale 1ns / 1ps
`default_nettype none

module pfc_pack
	import pfc_pkg::*;
(
	input  wire cfg_t        cfg,
	input  wire logic [23:0] masked,
	input  wire logic [23:0] rgb,
	output logic      [23:0] pixel_out
);

	logic [15:0] luma_sum;
	logic [7:0]  luma;
	logic [23:0] quant;
	logic [23:0] dmask;
	logic        same_fmt;
	logic [23:0] sel;

	assign luma_sum = {8'd0, rgb[23:16]} * LUMA_R
	                + {8'd0, rgb[15:8]}  * LUMA_G
	                + {8'd0, rgb[7:0]}   * LUMA_B;
	assign luma = luma_sum[15:8];

	always_comb begin
		case (cfg.dest_format)
			DST_G1: begin
				quant = {23'd0, luma[7]};
				dmask = 24'h000001;
			end
			DST_G2: begin
				quant = {22'd0, luma[7:6]};
				dmask = 24'h000003;
			end
			DST_G4: begin
				quant = {20'd0, luma[7:4]};
				dmask = 24'h00000f;
			end
			DST_G8: begin
				quant = {16'd0, luma};
				dmask = 24'h0000ff;
			end
			DST_RGB565: begin
				quant = {8'd0, rgb[23:19], rgb[15:10], rgb[7:3]};
				dmask = 24'h00ffff;
			end
			DST_RGB888: begin
				quant = rgb;
				dmask = 24'hffffff;
			end
			default: begin
				quant = '0;
				dmask = '0;
			end
		endcase
	end

	// Matching formats bypass the colour path
	always_comb begin
		case (cfg.source_format)
			SRC_G1, SRC_G2, SRC_G4, SRC_G8: same_fmt = (cfg.source_format == cfg.dest_format);
			SRC_RGB565: same_fmt = (cfg.dest_format == DST_RGB565);
			SRC_RGB888: same_fmt = (cfg.dest_format == DST_RGB888);
			default:    same_fmt = 1'b0;
		endcase
	end

	assign sel       = same_fmt ? masked : quant;
	assign pixel_out = (cfg.invert_enable ? ~sel : sel) & dmask;

endmodule

`default_nettype wire

>>> dv/pixel_format_converter_tb.sv
`timescale 1ns / 1ps

module pixel_format_converter_tb;
	import pfc_pkg::*;

	// Codes the package leaves unnamed: a spare register slot and the undefined formats
	localparam logic [1:0] REG_SPARE   = 2'd3;
	localparam logic [2:0] SRC_UNDEF   = 3'd7;
	localparam logic [2:0] DST_UNDEF_A = 3'd6;
	localparam logic [2:0] DST_UNDEF_B = 3'd7;

	localparam int unsigned DRAIN_LIMIT  = 5000;     // cycles allowed for the pipe to empty
	localparam int unsigned LONG_HOLD    = 96;       // receiver hold-off, in cycles
	localparam int unsigned REPORT_LIMIT = 40;       // mismatch lines printed before going quiet

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata   = '0;    // [23:0] source_pixel
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;           // [23:0] dest_pixel
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [2:0]  cfg_data  = '0;

	pixel_format_converter uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #6 clk = ~clk;

	// Register copies, updated on every accepted configuration beat
	logic [2:0] cur_source_format = SRC_G1;
	logic [2:0] cur_dest_format   = DST_G1;
	logic       cur_invert        = 1'b0;

	logic [23:0] pending_pixels[$];   // source pixels waiting to be driven
	logic [23:0] expected_pixels[$];  // converted pixels still owed by the block

	int unsigned pixels_sent     = 0;
	int unsigned pixels_accepted = 0;
	int unsigned pixels_checked  = 0;
	int unsigned mismatch_count  = 0;
	int unsigned settings_used   = 0;

	// Pacing knobs, set by the sequence and read by the driver and the receiver
	int unsigned gap_max       = 0;
	logic [15:0] ready_pattern = 16'hffff;
	bit          sender_hold   = 1'b0;
	bit          stall_request = 1'b0;

	// Driver and receiver private state
	bit          pixel_taken = 1'b0;
	int unsigned burst_left  = 1;
	int unsigned gap_left    = 0;
	int unsigned hold_left   = 0;
	logic [3:0]  ready_phase = '0;

	task automatic report_mismatch(input string what);
		if (mismatch_count < REPORT_LIMIT)
			$display("[%0t] mismatch: %s", $realtime, what);
		mismatch_count++;
	endtask

	function automatic int unsigned source_bits(input logic [2:0] fmt);
		case (fmt)
			SRC_G1:      return 1;
			SRC_G2:      return 2;
			SRC_G4:      return 4;
			SRC_G8:      return 8;
			SRC_RGBX222: return 6;
			SRC_RGB565:  return 16;
			SRC_RGB888:  return 24;
			default:     return 0;
		endcase
	endfunction

	// Expected destination pixel for one source pixel under the given settings
	function automatic logic [23:0] convert_pixel(input logic [2:0] src, input logic [2:0] dst,
			input logic inv, input logic [23:0] px);
		int unsigned dbits;
		logic [31:0] smask, dmask, v, y, r, g, b;
		logic [23:0] rgb;
		bit          passthru;

		case (dst)
			DST_G1:     dbits = 1;
			DST_G2:     dbits = 2;
			DST_G4:     dbits = 4;
			DST_G8:     dbits = 8;
			DST_RGB565: dbits = 16;
			DST_RGB888: dbits = 24;
			default:    dbits = 0;
		endcase
		smask = (source_bits(src) == 0) ? 32'd0 : ((32'd1 << source_bits(src)) - 32'd1);
		dmask = (dbits == 0) ? 32'd0 : ((32'd1 << dbits) - 32'd1);
		v = {8'd0, px} & smask;

		passthru = (src <= SRC_G8 && src == dst) ||
			(src == SRC_RGB565 && dst == DST_RGB565) ||
			(src == SRC_RGB888 && dst == DST_RGB888);

		if (!passthru) begin
			// Expand to 8-bit RGB
			case (src)
				SRC_G1, SRC_G2, SRC_G4, SRC_G8: begin
					y = (v * 32'd255) / smask;
					rgb = {y[7:0], y[7:0], y[7:0]};
				end
				SRC_RGBX222: begin
					rgb[23:16] = v[5:4] * 8'h55;
					rgb[15:8]  = v[3:2] * 8'h55;
					rgb[7:0]   = v[1:0] * 8'h55;
				end
				SRC_RGB565: rgb = {v[15:11], 3'b000, v[10:5], 2'b00, v[4:0], 3'b000};
				SRC_RGB888: rgb = v[23:0];
				default:    rgb = '0;
			endcase
			r = {24'd0, rgb[23:16]};
			g = {24'd0, rgb[15:8]};
			b = {24'd0, rgb[7:0]};
			// Quantise to the destination
			case (dst)
				DST_G1, DST_G2, DST_G4, DST_G8: begin
					y = (r * LUMA_R + g * LUMA_G + b * LUMA_B) >> 8;
					v = y >> (8 - dbits);
				end
				DST_RGB565: v = {16'd0, r[7:3], g[7:2], b[7:3]};
				DST_RGB888: v = {8'd0, rgb};
				default:    v = '0;
			endcase
		end
		if (inv)
			v = ~v;
		return v[23:0] & dmask[23:0];
	endfunction

	// Source pixel biased towards the edges of the format's depth
	function automatic logic [23:0] random_pixel(input logic [2:0] src);
		logic [23:0] depth_mask;

		depth_mask = (source_bits(src) == 0) ? 24'd0 : 24'((32'd1 << source_bits(src)) - 32'd1);
		case ($urandom_range(0, 9))
			0:       return 24'h000000;
			1:       return 24'hffffff;
			2, 3:    return 24'($urandom) & depth_mask;
			4:       return depth_mask | (24'($urandom) & ~depth_mask);
			default: return 24'($urandom);
		endcase
	endfunction

	// Sample every handshake on the rising edge; update the register copies, predict, check
	always @(posedge clk) begin
		logic [23:0] want;

		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SOURCE_FORMAT: cur_source_format = cfg_data;
					REG_DEST_FORMAT:   cur_dest_format   = cfg_data;
					REG_INVERT_ENABLE: cur_invert        = cfg_data[0];
					default:           ;
				endcase
			end
			// Check the output first: a result never leaves in the cycle its pixel arrives
			if (m_tvalid && m_tready) begin
				if (expected_pixels.size() == 0) begin
					report_mismatch($sformatf("result beat %h with nothing expected", m_tdata));
				end else begin
					want = expected_pixels.pop_front();
					if (m_tdata !== want)
						report_mismatch($sformatf("dest_pixel %h, expected %h (beat %0d)",
							m_tdata, want, pixels_checked));
					pixels_checked++;
				end
			end
			if (s_tvalid && s_tready) begin
				expected_pixels.push_back(convert_pixel(cur_source_format, cur_dest_format,
					cur_invert, s_tdata));
				pixels_accepted++;
				pixel_taken = 1'b1;
			end
		end
	end

	// Sender: bursts of random length split by random gaps; hold a beat until it is taken
	always @(negedge clk) begin
		if (arst_n && !(s_tvalid && !pixel_taken)) begin
			if (gap_left != 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (!sender_hold && pending_pixels.size() != 0) begin
				s_tdata  <= pending_pixels.pop_front();
				s_tvalid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					gap_left   = $urandom_range(0, gap_max);
				end else begin
					burst_left--;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		pixel_taken = 1'b0;
	end

	// Receiver: walk a rotating ready pattern, or hold off entirely when asked to
	always @(negedge clk) begin
		if (stall_request) begin
			stall_request = 1'b0;
			hold_left = LONG_HOLD;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ready_pattern[ready_phase];
		end
		ready_phase++;
	end

	// Advance to a point just past the falling edge, where every update has settled
	task automatic settle();
		@(negedge clk);
		#1;
	endtask

	task automatic send_pixel(input logic [23:0] px);
		pending_pixels.push_back(px);
		pixels_sent++;
	endtask

	// Wait until every pixel sent has come back, then let the pipe go quiet
	task automatic drain_pipe();
		int unsigned waited;

		waited = 0;
		while ((pixels_accepted != pixels_sent || expected_pixels.size() != 0 || s_tvalid)
				&& waited < DRAIN_LIMIT) begin
			settle();
			waited++;
		end
		if (waited >= DRAIN_LIMIT)
			report_mismatch($sformatf("%0d results never arrived", expected_pixels.size()));
		repeat (4) settle();
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [2:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// Write all three registers; the spare upper bits of the invert write are random
	task automatic apply_setting(input logic [2:0] src, input logic [2:0] dst, input logic inv);
		drain_pipe();
		write_reg(REG_SOURCE_FORMAT, src);
		write_reg(REG_DEST_FORMAT, dst);
		write_reg(REG_INVERT_ENABLE, {2'($urandom), inv});
		@(negedge clk);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// Random pacing for the next phase: sometimes none at all
	task automatic shuffle_pacing();
		case ($urandom_range(0, 3))
			0:       gap_max = 0;
			1:       gap_max = 2;
			default: gap_max = $urandom_range(0, 8);
		endcase
		case ($urandom_range(0, 3))
			0:       ready_pattern = 16'hffff;
			1:       ready_pattern = 16'h8001;
			default: ready_pattern = 16'($urandom) | 16'h0001;
		endcase
	endtask

	initial begin
		logic [6:0]  combos[128];
		logic [6:0]  swap;
		int unsigned j, n;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		settle();

		// Directed: reset settings (gray 1 to gray 1), plus a write to the unused slot
		write_reg(REG_SPARE, 3'b111);
		@(negedge clk);
		cfg_valid <= 1'b0;
		send_pixel(24'h000000);
		send_pixel(24'h000001);
		send_pixel(24'hfffffe);
		send_pixel(24'hffffff);

		// Same format passes the masked pixel through
		apply_setting(SRC_RGB565, DST_RGB565, 1'b0);
		send_pixel(24'hffffff);
		send_pixel(24'h00f81f);
		apply_setting(SRC_RGB888, DST_RGB888, 1'b1);
		send_pixel(24'h000000);
		send_pixel(24'h123456);

		// RGBX222 never counts as the same as RGB565; upper bits are dropped
		apply_setting(SRC_RGBX222, DST_RGB565, 1'b0);
		send_pixel(24'h00003f);
		send_pixel(24'hffffc0);

		// Gray down-scaling, inverted
		apply_setting(SRC_G4, DST_G2, 1'b1);
		send_pixel(24'h000000);
		send_pixel(24'h00000f);

		// Luma of white and mid grey
		apply_setting(SRC_RGB888, DST_G1, 1'b0);
		send_pixel(24'hffffff);
		send_pixel(24'h808080);

		// Undefined source expands to black, then inverts as usual
		apply_setting(SRC_UNDEF, DST_RGB888, 1'b1);
		send_pixel(24'hffffff);

		// Undefined destinations yield zero, inverted or not
		apply_setting(SRC_RGB888, DST_UNDEF_A, 1'b1);
		send_pixel(24'hffffff);
		apply_setting(SRC_G8, DST_UNDEF_B, 1'b0);
		send_pixel(24'h0000aa);

		// Gray up-scaling and RGB565 expansion
		apply_setting(SRC_G1, DST_G8, 1'b1);
		send_pixel(24'h000001);
		send_pixel(24'h000000);
		apply_setting(SRC_RGB565, DST_RGB888, 1'b0);
		send_pixel(24'h00ffff);
		send_pixel(24'h008410);

		// Random: every source, destination and invert combination once, in random order
		for (int unsigned k = 0; k < 128; k++)
			combos[k] = 7'(k);
		for (int unsigned k = 127; k > 0; k--) begin
			j = $urandom_range(0, k);
			swap = combos[k];
			combos[k] = combos[j];
			combos[j] = swap;
		end

		for (int unsigned k = 0; k < 128; k++) begin
			apply_setting(combos[k][6:4], combos[k][3:1], combos[k][0]);
			shuffle_pacing();
			n = $urandom_range(3, 6);
			if (k == 20) begin
				// Hold the output off while pixels keep streaming in, so the input backs up
				gap_max = 0;
				stall_request = 1'b1;
				n = 40;
			end
			for (int unsigned i = 0; i < n; i++)
				send_pixel(random_pixel(combos[k][6:4]));
			if (k == 60) begin
				// Pause the sender mid-stream until every owed result is back
				for (int unsigned i = 0; i < 20; i++)
					send_pixel(random_pixel(combos[k][6:4]));
				while (pixels_accepted + 12 < pixels_sent)
					settle();
				sender_hold = 1'b1;
				while (s_tvalid || expected_pixels.size() != 0)
					settle();
				sender_hold = 1'b0;
			end
		end

		drain_pipe();
		if (expected_pixels.size() != 0)
			report_mismatch($sformatf("%0d results left over", expected_pixels.size()));

		$display("Converted %0d pixels across %0d format settings, %0d results checked.",
			pixels_accepted, settings_used, pixels_checked);
		$display("Covered every format pair, undefined formats, inversion and back-pressure; %0d mismatches.",
			mismatch_count);
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Run limit, many times the slowest correct run
	initial begin
		#(12 * 300000);
		$display("FAIL");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/pfc_pkg.sv
rtl/core/pfc_cfg_regs.sv
rtl/core/pfc_expand.sv
rtl/core/pfc_pack.sv
rtl/core/pixel_format_converter.sv
dv/pixel_format_converter_tb.sv
